/* design/xlsu_pkg.sv */
package xlsu_pkg;

    // Operation codes
    localparam logic [3:0] OP_TEST  = 4'd0;
    localparam logic [3:0] OP_AND   = 4'd1;
    localparam logic [3:0] OP_XOR   = 4'd2;
    localparam logic [3:0] OP_OR    = 4'd3;
    localparam logic [3:0] OP_SAR   = 4'd4;
    localparam logic [3:0] OP_SHL   = 4'd5;
    localparam logic [3:0] OP_SHR   = 4'd6;
    localparam logic [3:0] OP_NOT   = 4'd7;
    localparam logic [3:0] OP_ROL   = 4'd8;
    localparam logic [3:0] OP_SHRD  = 4'd9;
    localparam logic [3:0] OP_SHLD  = 4'd10;
    localparam logic [3:0] OP_SETCC = 4'd11;

    // Operand size codes; the spare code behaves as dword
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;

    // Condition groups (condition code without its invert bit)
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_Z  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [1:0]  size_code;
        logic [31:0] dest_val;
        logic [31:0] src_val;
        logic [31:0] src2_val;
        logic [3:0]  cond_code;
        logic        cf_in;
        logic        of_in;
        logic        zf_in;
        logic        sf_in;
        logic        pf_in;
    } xlsu_req_t;

    typedef struct packed {
        logic [31:0] result;
        logic        write_dest;
        logic        cf_out;
        logic        of_out;
        logic        zf_out;
        logic        sf_out;
    } xlsu_rsp_t;

endpackage

/* design/x86_logic_shift_unit_core.sv */
// Channel    Ports          Handshake                       Word
// ---------  -------------  ------------------------------  ----------
// request    start, req     taken when start & !busy        xlsu_req_t
// response   done, rsp      done high for one cycle only    xlsu_rsp_t
//
// The request word lands in the input register at the accepting edge, and
// its response word sits in the result register from the next edge on,
// with done high for exactly that cycle.
// One word is taken every cycle; busy is never raised.
// rst_n clears both valid bits asynchronously; payload registers are not reset.
// The receiver cannot stall, so the response is dropped after its cycle.
module x86_logic_shift_unit_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  xlsu_pkg::xlsu_req_t req,
    output logic              done,
    output xlsu_pkg::xlsu_rsp_t rsp
);
    import xlsu_pkg::*;

    xlsu_req_t   req_reg;
    logic        in_vld_reg;
    xlsu_rsp_t   rsp_reg;
    xlsu_rsp_t   rsp_next;
    logic        done_reg;

    logic [5:0]  w;
    logic [31:0] m;
    logic [31:0] d;
    logic [31:0] s2;
    logic [4:0]  c;
    logic [5:0]  k;
    logic [31:0] sar_fill;
    logic [63:0] cat_r;
    logic [63:0] cat_l;
    logic [63:0] shrd_full;
    logic [63:0] shld_full;
    logic [31:0] rol_full;
    logic [31:0] r;
    logic        wr;
    logic        cf;
    logic        of;
    logic        zf;
    logic        sf;
    logic        zs;
    logic        is_shift;
    logic        cond;

    function automatic logic top_of(input logic [31:0] v, input logic [1:0] sz);
        logic t;
        unique case (sz)
            SIZE_BYTE: t = v[7];
            SIZE_WORD: t = v[15];
            default:   t = v[31];
        endcase
        return t;
    endfunction

    // Never stall: every cycle can take a new word
    assign busy = 1'b0;

    // Width, mask and rotate count for the operand size
    always_comb
    begin
        unique case (req_reg.size_code)
            SIZE_BYTE:
            begin
                w = 6'd8;
                m = 32'h0000_00ff;
                k = {3'b000, c[2:0]};
            end
            SIZE_WORD:
            begin
                w = 6'd16;
                m = 32'h0000_ffff;
                k = {2'b00, c[3:0]};
            end
            default:
            begin
                w = 6'd32;
                m = 32'hffff_ffff;
                k = {1'b0, c};
            end
        endcase
    end

    assign d  = req_reg.dest_val & m;
    assign s2 = req_reg.src2_val & m;
    assign c  = req_reg.src_val[4:0];

    // Sign fill lands at the top of the 32-bit word and is then masked
    assign sar_fill = {32{top_of(d, req_reg.size_code)}} & ~(32'hffff_ffff >> c);

    // Double shifts work on the size-truncated pair, zeros beyond it
    assign cat_r     = ({32'd0, s2} << w) | {32'd0, d};
    assign cat_l     = ({32'd0, d} << w) | {32'd0, s2};
    assign shrd_full = cat_r >> c;
    assign shld_full = (cat_l << c) >> w;

    // A zero rotate count falls out naturally: d >> w is zero for masked d
    assign rol_full = (d << k) | (d >> (w - k));

    always_comb
    begin
        unique case (req_reg.cond_code[3:1])
            CC_O:    cond = req_reg.of_in;
            CC_B:    cond = req_reg.cf_in;
            CC_Z:    cond = req_reg.zf_in;
            CC_BE:   cond = req_reg.cf_in | req_reg.zf_in;
            CC_S:    cond = req_reg.sf_in;
            CC_P:    cond = req_reg.pf_in;
            CC_L:    cond = req_reg.sf_in ^ req_reg.of_in;
            default: cond = req_reg.zf_in | (req_reg.sf_in ^ req_reg.of_in);
        endcase
    end

    assign is_shift = (req_reg.req_type == OP_SAR) || (req_reg.req_type == OP_SHL) ||
                      (req_reg.req_type == OP_SHR) || (req_reg.req_type == OP_ROL) ||
                      (req_reg.req_type == OP_SHRD) || (req_reg.req_type == OP_SHLD);

    always_comb
    begin
        r  = 32'd0;
        wr = 1'b1;
        cf = req_reg.cf_in;
        of = req_reg.of_in;
        zf = req_reg.zf_in;
        sf = req_reg.sf_in;
        zs = 1'b0;
        if (is_shift && (c == 5'd0))
        begin
            // Zero count: pass the operand, keep every flag
            r = d;
        end
        else
        begin
            case (req_reg.req_type)
                OP_TEST:
                begin
                    r  = d & req_reg.src_val;
                    wr = 1'b0;
                    cf = 1'b0;
                    of = 1'b0;
                    zs = 1'b1;
                end
                OP_AND:
                begin
                    r  = d & req_reg.src_val;
                    cf = 1'b0;
                    of = 1'b0;
                    zs = 1'b1;
                end
                OP_XOR:
                begin
                    r  = (d ^ req_reg.src_val) & m;
                    cf = 1'b0;
                    of = 1'b0;
                    zs = 1'b1;
                end
                OP_OR:
                begin
                    r  = (d | req_reg.src_val) & m;
                    cf = 1'b0;
                    of = 1'b0;
                    zs = 1'b1;
                end
                OP_SAR:
                begin
                    r  = ((d >> c) | sar_fill) & m;
                    zs = 1'b1;
                end
                OP_SHL:
                begin
                    r  = (d << c) & m;
                    zs = 1'b1;
                end
                OP_SHR:
                begin
                    r  = d >> c;
                    zs = 1'b1;
                end
                OP_NOT:
                begin
                    r = ~d & m;
                end
                OP_ROL:
                begin
                    r  = rol_full & m;
                    cf = r[0];
                    of = top_of(r, req_reg.size_code) ^ r[0];
                end
                OP_SHRD:
                begin
                    r  = shrd_full[31:0] & m;
                    zs = 1'b1;
                end
                OP_SHLD:
                begin
                    r  = shld_full[31:0] & m;
                    zs = 1'b1;
                end
                OP_SETCC:
                begin
                    r = {31'd0, cond ^ req_reg.cond_code[0]};
                end
                default:
                begin
                    // Unused codes: no write, flags untouched
                    r  = 32'd0;
                    wr = 1'b0;
                end
            endcase
        end
        if (zs)
        begin
            zf = (r == 32'd0);
            sf = top_of(r, req_reg.size_code);
        end
        rsp_next.result     = r;
        rsp_next.write_dest = wr;
        rsp_next.cf_out     = cf;
        rsp_next.of_out     = of;
        rsp_next.zf_out     = zf;
        rsp_next.sf_out     = sf;
    end

    // Valid bits: advance one stage per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start & ~busy;
            done_reg   <= in_vld_reg;
        end
    end

    // Payload: hold the request word, capture the response word
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        if (in_vld_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
